// ----- design/assert_macros.svh -----
// Assertion macros shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bpsd_pkg.sv -----
// Shared types and constants of the breath phase slope detector.
`timescale 1ns / 1ps
package bpsd_pkg;

    localparam int TW    = 20;
    localparam int VW    = 16;
    localparam int QW    = 32;
    localparam int WLW   = 7;
    localparam int CFG_IW = 3;
    localparam int QBITS = 31;

    localparam logic [WLW-1:0] WINDOW_LEN_RST = 7'd8;
    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IW-1:0] {
        CFG_WINDOW_LEN     = 3'd0,
        CFG_UP_SLOPE_MIN   = 3'd1,
        CFG_PEAK_RATIO_MAX = 3'd2,
        CFG_DOWN_SLOPE_MIN = 3'd3,
        CFG_DOWN_SLOPE_MAX = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_REST   = 2'd0,
        PH_INHALE = 2'd1,
        PH_EXHALE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [WLW-1:0]       window_len;
        logic signed [QW-1:0] up_slope_min;
        logic signed [QW-1:0] peak_ratio_max;
        logic signed [QW-1:0] down_slope_min;
        logic signed [QW-1:0] down_slope_max;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic rd_win;
        logic sq;
        logic fill;
        logic prod;
        logic diff;
        logic slope_go;
        logic slide;
        logic step;
        logic decide;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic priming;
        logic div_busy;
        logic changed;
        logic out_free;
    } stat_t;

endpackage

// ----- design/bpsd_div.sv -----
// Bit-serial saturating Q16.16 divider of two magnitudes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpsd_div #(
    parameter int MW = 53
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [MW-1:0]                   num,
    input  logic [MW-1:0]                   den,
    input  logic                            neg,
    output logic                            busy,
    output logic signed [bpsd_pkg::QW-1:0]  quo
);

    localparam int CNTW = $clog2(bpsd_pkg::QBITS);

    logic                           busy_reg;
    logic                           first_reg;
    logic [CNTW-1:0]                cnt_reg;
    logic [MW-1:0]                  r_reg;
    logic [MW-1:0]                  den_reg;
    logic [bpsd_pkg::QBITS-1:0]     low_reg;
    logic [bpsd_pkg::QBITS-1:0]     qm_reg;
    logic                           neg_reg;
    logic signed [bpsd_pkg::QW-1:0] quo_reg;

    logic [MW:0]                    r2;
    logic [MW:0]                    rsub;
    logic                           ge;
    logic [bpsd_pkg::QBITS-1:0]     mag_next;
    logic                           last_step;

    // One quotient bit per cycle; the remainder always stays below the divisor.
    assign r2        = {r_reg, low_reg[bpsd_pkg::QBITS-1]};
    assign rsub      = r2 - {1'b0, den_reg};
    assign ge        = r2 >= {1'b0, den_reg};
    assign mag_next  = {qm_reg[bpsd_pkg::QBITS-2:0], ge};
    assign last_step = cnt_reg == CNTW'(bpsd_pkg::QBITS - 1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            first_reg <= 1'b1;
            cnt_reg   <= '0;
        end else if (busy_reg) begin
            if (first_reg) begin
                // An integer part of 2^15 or more saturates at once.
                first_reg <= 1'b0;
                if (r_reg >= den_reg) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            r_reg   <= MW'(num >> 15);
            den_reg <= den;
            low_reg <= {num[14:0], 16'h0000};
            neg_reg <= neg;
            qm_reg  <= '0;
        end else if (busy_reg) begin
            if (first_reg) begin
                if (r_reg >= den_reg) begin
                    quo_reg <= neg_reg ? bpsd_pkg::Q_MIN : bpsd_pkg::Q_MAX;
                end
            end else begin
                r_reg   <= ge ? rsub[MW-1:0] : r2[MW-1:0];
                qm_reg  <= mag_next;
                low_reg <= {low_reg[bpsd_pkg::QBITS-2:0], 1'b0};
                if (last_step) begin
                    quo_reg <= neg_reg ? -$signed({1'b0, mag_next})
                                       : $signed({1'b0, mag_next});
                end
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

    `ASSERT_IMP(a_no_start_busy, clk, rst_n, start, !busy_reg)
    `ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_reg)

endmodule

// ----- design/bpsd_dp.sv -----
// Datapath: sample ring, running sums, slope products, divider and phase logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpsd_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpsd_pkg::cfg_t                      cfg,
    input  logic                                win_clear,
    input  bpsd_pkg::cmd_t                      cmd,
    output bpsd_pkg::stat_t                     st,
    input  logic [bpsd_pkg::TW-1:0]             sample_time,
    input  logic signed [bpsd_pkg::VW-1:0]      sample_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpsd_pkg::TW-1:0]             event_time,
    output logic signed [bpsd_pkg::VW-1:0]      event_value,
    output logic [1:0]                          event_phase
);

    localparam int TW   = bpsd_pkg::TW;
    localparam int VW   = bpsd_pkg::VW;
    localparam int QW   = bpsd_pkg::QW;
    localparam int LW   = $clog2(MAX_WINDOW);
    localparam int KW   = $clog2(MAX_WINDOW + 1);
    localparam int CW   = (KW > bpsd_pkg::WLW) ? KW : bpsd_pkg::WLW;
    localparam int STW  = TW + LW;
    localparam int SYW  = VW + LW;
    localparam int STTW = 2 * TW + LW;
    localparam int STYW = TW + VW + LW;
    localparam int DW   = 2 * TW + 2 * LW + 2;
    localparam int MW   = DW - 1;

    // Window ring.
    logic [TW+VW-1:0] win_mem [MAX_WINDOW];
    logic [TW+VW-1:0] rd_reg;

    logic [TW-1:0]            t_in_reg;
    logic signed [VW-1:0]     y_in_reg;
    logic [2*TW-1:0]          tt_new_reg;
    logic signed [TW+VW-1:0]  ty_new_reg;
    logic [2*TW-1:0]          tt_old_reg;
    logic signed [TW+VW-1:0]  ty_old_reg;
    logic signed [DW-1:0]     p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [DW-1:0]     num_reg, den_reg;

    logic [STW-1:0]           sum_t_reg;
    logic signed [SYW-1:0]    sum_y_reg;
    logic [STTW-1:0]          sum_tt_reg;
    logic signed [STYW-1:0]   sum_ty_reg;
    logic signed [QW-1:0]     cs_reg, es_reg;
    bpsd_pkg::phase_t         phase_reg, nph_reg;
    logic signed [VW-1:0]     last_reg;
    logic [KW-1:0]            fill_reg;
    logic [LW-1:0]            wp_reg;
    logic                     upd_reg, fell_reg, chg_reg, rpend_reg, changed_reg;

    logic                     out_valid_reg;
    logic [TW-1:0]            event_time_reg;
    logic signed [VW-1:0]     event_value_reg;
    logic [1:0]               event_phase_reg;

    logic [CW-1:0]            wl_ext;
    logic [KW-1:0]            k_eff;
    logic [LW:0]              base_sum;
    logic [LW-1:0]            base;
    logic [LW-1:0]            wp_inc;
    logic [TW-1:0]            t_old;
    logic signed [VW-1:0]     y_old;
    logic [MW-1:0]            num_mag, den_mag;
    logic [QW-1:0]            cs_mag, es_mag;
    logic                     den_nz, es_nz;
    logic                     div_start, div_neg, div_busy;
    logic [MW-1:0]            div_num, div_den;
    logic signed [QW-1:0]     quo;
    logic                     chg_final;
    logic                     mem_we;

    // Effective window length, saturated into [2, MAX_WINDOW].
    assign wl_ext = CW'(cfg.window_len);
    always_comb begin
        priority if (wl_ext < CW'(2)) begin
            k_eff = KW'(2);
        end else if (wl_ext > CW'(MAX_WINDOW)) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(wl_ext);
        end
    end

    // Oldest entry of the window, K places behind the write pointer.
    assign base_sum = {1'b0, wp_reg} + (LW+1)'(MAX_WINDOW) - (LW+1)'(k_eff);
    assign base     = (base_sum >= (LW+1)'(MAX_WINDOW))
                      ? LW'(base_sum - (LW+1)'(MAX_WINDOW)) : LW'(base_sum);
    assign wp_inc   = (wp_reg == LW'(MAX_WINDOW - 1)) ? '0 : wp_reg + LW'(1);

    assign t_old = rd_reg[TW+VW-1:VW];
    assign y_old = $signed(rd_reg[VW-1:0]);

    assign mem_we = cmd.fill || cmd.slide;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            win_mem[wp_reg] <= {t_in_reg, y_in_reg};
        end
        if (cmd.rd_win) begin
            rd_reg <= win_mem[base];
        end
    end

    // Divider operand selection: window slope, or slope ratio in inhalation.
    assign num_mag = num_reg[DW-1] ? MW'(-num_reg) : MW'(num_reg);
    assign den_mag = den_reg[DW-1] ? MW'(-den_reg) : MW'(den_reg);
    assign cs_mag  = cs_reg[QW-1] ? QW'(-cs_reg) : QW'(cs_reg);
    assign es_mag  = es_reg[QW-1] ? QW'(-es_reg) : QW'(es_reg);
    assign den_nz  = den_reg != '0;
    assign es_nz   = es_reg != '0;

    assign div_num   = cmd.step ? MW'(cs_mag) : num_mag;
    assign div_den   = cmd.step ? MW'(es_mag) : den_mag;
    assign div_neg   = cmd.step
                       ? ((cs_reg[QW-1] != es_reg[QW-1]) && (cs_reg != '0))
                       : ((num_reg[DW-1] != den_reg[DW-1]) && (num_reg != '0));
    assign div_start = (cmd.slope_go && den_nz)
                       || (cmd.step && (phase_reg == bpsd_pkg::PH_INHALE) && es_nz);

    bpsd_div #(
        .MW(MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .neg   (div_neg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign chg_final = rpend_reg ? ((quo < cfg.peak_ratio_max) && fell_reg) : chg_reg;

    // Per-item operand and product registers.
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            t_in_reg <= sample_time;
            y_in_reg <= sample_value;
        end
        if (cmd.sq) begin
            tt_new_reg <= t_in_reg * t_in_reg;
            ty_new_reg <= $signed({1'b0, t_in_reg}) * y_in_reg;
        end
        if (cmd.prod) begin
            p1_reg     <= $signed({1'b0, k_eff}) * sum_ty_reg;
            p2_reg     <= $signed({1'b0, sum_t_reg}) * sum_y_reg;
            p3_reg     <= $signed({1'b0, k_eff}) * $signed({1'b0, sum_tt_reg});
            p4_reg     <= $signed({1'b0, sum_t_reg}) * $signed({1'b0, sum_t_reg});
            tt_old_reg <= t_old * t_old;
            ty_old_reg <= $signed({1'b0, t_old}) * y_old;
        end
        if (cmd.diff) begin
            num_reg <= p1_reg - p2_reg;
            den_reg <= p3_reg - p4_reg;
        end
    end

    // Detector state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sum_t_reg   <= '0;
            sum_y_reg   <= '0;
            sum_tt_reg  <= '0;
            sum_ty_reg  <= '0;
            fill_reg    <= '0;
            wp_reg      <= '0;
            cs_reg      <= '0;
            es_reg      <= '0;
            phase_reg   <= bpsd_pkg::PH_REST;
            nph_reg     <= bpsd_pkg::PH_REST;
            last_reg    <= '0;
            upd_reg     <= 1'b0;
            fell_reg    <= 1'b0;
            chg_reg     <= 1'b0;
            rpend_reg   <= 1'b0;
            changed_reg <= 1'b0;
        end else begin
            if (win_clear) begin
                sum_t_reg  <= '0;
                sum_y_reg  <= '0;
                sum_tt_reg <= '0;
                sum_ty_reg <= '0;
                fill_reg   <= '0;
            end else if (cmd.fill) begin
                sum_t_reg  <= sum_t_reg + STW'(t_in_reg);
                sum_y_reg  <= sum_y_reg + SYW'(y_in_reg);
                sum_tt_reg <= sum_tt_reg + STTW'(tt_new_reg);
                sum_ty_reg <= sum_ty_reg + STYW'(ty_new_reg);
                fill_reg   <= fill_reg + KW'(1);
            end else if (cmd.slide) begin
                sum_t_reg  <= sum_t_reg + STW'(t_in_reg) - STW'(t_old);
                sum_y_reg  <= sum_y_reg + SYW'(y_in_reg) - SYW'(y_old);
                sum_tt_reg <= sum_tt_reg + STTW'(tt_new_reg) - STTW'(tt_old_reg);
                sum_ty_reg <= sum_ty_reg + STYW'(ty_new_reg) - STYW'(ty_old_reg);
            end
            if (mem_we) begin
                wp_reg   <= wp_inc;
                last_reg <= y_in_reg;
            end
            if (cmd.slope_go) begin
                upd_reg <= den_nz;
            end
            if (cmd.slide) begin
                es_reg   <= cs_reg;
                fell_reg <= y_in_reg < last_reg;
                if (upd_reg) begin
                    cs_reg <= quo;
                end
            end
            if (cmd.step) begin
                unique case (phase_reg)
                    bpsd_pkg::PH_REST: begin
                        chg_reg   <= cs_reg > cfg.up_slope_min;
                        nph_reg   <= bpsd_pkg::PH_INHALE;
                        rpend_reg <= 1'b0;
                    end
                    bpsd_pkg::PH_INHALE: begin
                        chg_reg   <= 1'b0;
                        nph_reg   <= bpsd_pkg::PH_EXHALE;
                        rpend_reg <= es_nz;
                    end
                    bpsd_pkg::PH_EXHALE: begin
                        chg_reg   <= (cs_reg > cfg.down_slope_min)
                                     && (cs_reg < cfg.down_slope_max);
                        nph_reg   <= bpsd_pkg::PH_REST;
                        rpend_reg <= 1'b0;
                    end
                    default: begin
                        chg_reg   <= 1'b0;
                        nph_reg   <= phase_reg;
                        rpend_reg <= 1'b0;
                    end
                endcase
            end
            if (cmd.decide) begin
                changed_reg <= chg_final;
                if (chg_final) begin
                    phase_reg <= nph_reg;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            event_time_reg  <= t_old;
            event_value_reg <= y_old;
            event_phase_reg <= phase_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_time  = event_time_reg;
    assign event_value = event_value_reg;
    assign event_phase = event_phase_reg;

    assign st.priming  = fill_reg < k_eff;
    assign st.div_busy = div_busy;
    assign st.changed  = changed_reg;
    assign st.out_free = !out_valid_reg || out_ready;

    `ASSERT_IMP(a_fill_le_k, clk, rst_n, 1'b1, fill_reg <= k_eff)
    `ASSERT_IMP(a_wp_range, clk, rst_n, 1'b1, wp_reg <= LW'(MAX_WINDOW - 1))
    `ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)

endmodule

// ----- design/bpsd_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module bpsd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bpsd_pkg::stat_t st,
    output bpsd_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_FILL,
        S_PROD,
        S_DIFF,
        S_DIV,
        S_WDIV,
        S_SLIDE,
        S_STEP,
        S_WRAT,
        S_DECIDE,
        S_RDNEW,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = in_valid && in_ready_reg;
                if (cmd.capture) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.rd_win = 1'b1;
                cmd.sq     = 1'b1;
                state_next = st.priming ? S_FILL : S_PROD;
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_IDLE;
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.slope_go = 1'b1;
                state_next   = S_WDIV;
            end
            S_WDIV: begin
                if (!st.div_busy) begin
                    state_next = S_SLIDE;
                end
            end
            S_SLIDE: begin
                cmd.slide  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                cmd.step   = 1'b1;
                state_next = S_WRAT;
            end
            S_WRAT: begin
                if (!st.div_busy) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_RDNEW;
            end
            S_RDNEW: begin
                cmd.rd_win = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                priority if (!st.changed) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    // The previous event item is still waiting to be taken.
                    state_next = S_EMIT;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            in_ready_reg <= state_next == S_IDLE;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ----- design/breath_phase_slope_detector_core.sv -----
// Top level of the breath phase slope detector: configuration registers and core.
`timescale 1ns / 1ps
// The block takes one timed breathing sample per item on the input channel
// (in_valid/in_ready, sample_time, sample_value) and gives one item on the
// output channel (out_valid/out_ready, event_time, event_value, event_phase)
// each time the rest/inhalation/exhalation phase changes.
// The first window_len samples (clamped to 2..MAX_WINDOW) after reset or
// after a window_len write only prime the window sums and produce nothing.
// A full item runs the window slope through the bit-serial divider, and
// in inhalation a second division for the slope ratio, before the block is
// ready again. The divider sets the rate.
// An event is placed in the output register at the end of the item and waits
// there while the receiver stalls; the next item is accepted meanwhile, and
// only a second event stalls the block until the first one is taken.
// Reset clears the sums, slopes and phase (rest) and loads the default
// configuration (window of 8, all limits zero). The user must write configuration
// through cfg_write/cfg_index/cfg_data while the block is idle (not enforced).
module breath_phase_slope_detector_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpsd_pkg::TW-1:0]             sample_time,
    input  logic signed [bpsd_pkg::VW-1:0]      sample_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpsd_pkg::TW-1:0]             event_time,
    output logic signed [bpsd_pkg::VW-1:0]      event_value,
    output logic [1:0]                          event_phase,
    input  logic                                cfg_write,
    input  logic [bpsd_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [bpsd_pkg::QW-1:0]             cfg_data
);

    bpsd_pkg::cfg_t  cfg_reg;
    bpsd_pkg::cmd_t  cmd;
    bpsd_pkg::stat_t st;
    logic            win_clear;

    // A new window length restarts priming of the sums.
    assign win_clear = cfg_write && (cfg_index == bpsd_pkg::CFG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.window_len     <= bpsd_pkg::WINDOW_LEN_RST;
            cfg_reg.up_slope_min   <= '0;
            cfg_reg.peak_ratio_max <= '0;
            cfg_reg.down_slope_min <= '0;
            cfg_reg.down_slope_max <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                bpsd_pkg::CFG_WINDOW_LEN:
                    cfg_reg.window_len <= cfg_data[bpsd_pkg::WLW-1:0];
                bpsd_pkg::CFG_UP_SLOPE_MIN:
                    cfg_reg.up_slope_min <= $signed(cfg_data);
                bpsd_pkg::CFG_PEAK_RATIO_MAX:
                    cfg_reg.peak_ratio_max <= $signed(cfg_data);
                bpsd_pkg::CFG_DOWN_SLOPE_MIN:
                    cfg_reg.down_slope_min <= $signed(cfg_data);
                bpsd_pkg::CFG_DOWN_SLOPE_MAX:
                    cfg_reg.down_slope_max <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    bpsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bpsd_dp #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .win_clear    (win_clear),
        .cmd          (cmd),
        .st           (st),
        .sample_time  (sample_time),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_time   (event_time),
        .event_value  (event_value),
        .event_phase  (event_phase)
    );

endmodule

// ----- sim/breath_phase_slope_detector_core_tb.sv -----
// Self-checking testbench for the breath phase slope detector core.
`timescale 1ns / 1ps
// Each accepted sample item is fed to a predictor of the windowed
// least-squares slope and the rest/inhalation/exhalation machine. The
// predictor queues the expected phase-change event, and a checker compares
// every event item taken from the block against the oldest expected one.
// Both channels idle at random, except in the last test.
module breath_phase_slope_detector_core_tb;

    localparam int WIN_DEPTH  = 64;
    localparam int DRAIN_WAIT = 100;  // longer than the slowest item
    localparam int STUCK_MAX  = 5000;
    localparam longint SLOPE_MAX = 64'sd2147483647;
    localparam longint SLOPE_MIN = -64'sd2147483648;

    typedef struct {
        logic [bpsd_pkg::TW-1:0]        t;
        logic signed [bpsd_pkg::VW-1:0] v;
        bpsd_pkg::phase_t               ph;
    } breath_event_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [bpsd_pkg::TW-1:0]        sample_time = '0;
    logic signed [bpsd_pkg::VW-1:0] sample_value = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [bpsd_pkg::TW-1:0]        event_time;
    logic signed [bpsd_pkg::VW-1:0] event_value;
    logic [1:0]                     event_phase;
    logic                           cfg_write = 1'b0;
    logic [bpsd_pkg::CFG_IW-1:0]    cfg_index = '0;
    logic [bpsd_pkg::QW-1:0]        cfg_data = '0;

    breath_phase_slope_detector_core #(.MAX_WINDOW(WIN_DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_time(sample_time), .sample_value(sample_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_time(event_time), .event_value(event_value), .event_phase(event_phase),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor state: the sample ring, the running sums and the phase machine.
    int      ring_time [WIN_DEPTH];
    int      ring_value [WIN_DEPTH];
    longint  acc_t, acc_y, acc_tt, acc_ty;
    longint  slope_now, slope_prev;
    bpsd_pkg::phase_t breath_phase;
    int      prev_value;
    int      primed;
    int      head;
    int      win_len_reg;
    longint  up_min, peak_max, band_lo, band_hi;

    breath_event_t pending_events[$];
    int  error_count = 0;
    bit  calm = 1'b0;        // no idling on either side when set
    int  stuck_cycles = 0;
    int  rdy_left = 0;
    logic [bpsd_pkg::TW-1:0] clock_stamp = '0;

    // Truncated, saturated Q16.16 quotient of two magnitudes; den is nonzero.
    function automatic longint q16_quotient(longint unsigned num, longint unsigned den,
                                            bit neg);
        longint unsigned whole, rem, frac;
        longint mag;
        whole = num / den;
        rem = num % den;
        frac = 0;
        if (whole >= 64'd32768)
            return neg ? SLOPE_MIN : SLOPE_MAX;
        for (int b = 0; b < 16; b++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                frac = frac | 64'd1;
            end
        end
        mag = longint'((whole << 16) | frac);
        return neg ? -mag : mag;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    task automatic restart_priming();
        acc_t = 0;
        acc_y = 0;
        acc_tt = 0;
        acc_ty = 0;
        primed = 0;
    endtask

    // Advances the predictor by one sample and queues the event it causes.
    task automatic predict_sample(input logic [bpsd_pkg::TW-1:0] t,
                                  input logic signed [bpsd_pkg::VW-1:0] y);
        int k, gone, oldest;
        int t_in, y_in, t_out, y_out;
        longint st, num, den, ratio;
        bit fell;
        bpsd_pkg::phase_t was;
        breath_event_t ev;
        k = win_len_reg;
        if (k < 2) k = 2;
        if (k > WIN_DEPTH) k = WIN_DEPTH;
        t_in = t;
        y_in = y;
        if (primed < k)
        begin
            ring_time[head] = t_in;
            ring_value[head] = y_in;
            head = (head + 1) % WIN_DEPTH;
            acc_t += t_in;
            acc_y += y_in;
            acc_tt += longint'(t_in) * t_in;
            acc_ty += longint'(t_in) * y_in;
            primed++;
            prev_value = y_in;
            return;
        end
        // Slope of the window as it stood before this sample.
        st = acc_t;
        num = k * acc_ty - st * acc_y;
        den = k * acc_tt - st * st;
        slope_prev = slope_now;
        if (den != 0)
            slope_now = q16_quotient(magnitude(num), magnitude(den),
                                     ((num < 0) != (den < 0)) && num != 0);
        gone = (head + WIN_DEPTH - k) % WIN_DEPTH;
        t_out = ring_time[gone];
        y_out = ring_value[gone];
        ring_time[head] = t_in;
        ring_value[head] = y_in;
        head = (head + 1) % WIN_DEPTH;
        acc_t += t_in - t_out;
        acc_y += y_in - y_out;
        acc_tt += longint'(t_in) * t_in - longint'(t_out) * t_out;
        acc_ty += longint'(t_in) * y_in - longint'(t_out) * y_out;
        fell = y_in < prev_value;
        prev_value = y_in;
        was = breath_phase;
        case (breath_phase)
            bpsd_pkg::PH_REST:
                if (slope_now > up_min)
                    breath_phase = bpsd_pkg::PH_INHALE;
            bpsd_pkg::PH_INHALE:
                // A zero earlier slope never declares the peak.
                if (slope_prev != 0)
                begin
                    ratio = q16_quotient(magnitude(slope_now), magnitude(slope_prev),
                                         ((slope_now < 0) != (slope_prev < 0)) &&
                                         slope_now != 0);
                    if (ratio < peak_max && fell)
                        breath_phase = bpsd_pkg::PH_EXHALE;
                end
            default:
                if (slope_now > band_lo && slope_now < band_hi)
                    breath_phase = bpsd_pkg::PH_REST;
        endcase
        if (breath_phase != was)
        begin
            oldest = (head + WIN_DEPTH - k) % WIN_DEPTH;
            ev.t = ring_time[oldest];
            ev.v = ring_value[oldest];
            ev.ph = breath_phase;
            pending_events = {pending_events, ev};
        end
    endtask

    // Sends one sample item and waits for it to be taken; called at a clock edge.
    task automatic send_sample(input logic [bpsd_pkg::TW-1:0] t,
                               input logic signed [bpsd_pkg::VW-1:0] y);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_time <= t;
        sample_value <= y;
        do
            @(posedge clk);
        while (!in_ready);
        predict_sample(t, y);
    endtask

    // Moves the time stamp forward by step and sends the value.
    task automatic send_after(input int step, input int y);
        clock_stamp = clock_stamp + bpsd_pkg::TW'(step);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        send_sample(clock_stamp, bpsd_pkg::VW'(y));
    endtask

    // Lets every expected event arrive and the block go idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes all five registers; only called once the block has drained.
    task automatic program_limits(input int wl, input longint up, input longint pk,
                                  input longint lo, input longint hi);
        bpsd_pkg::cfg_idx_t idx;
        logic [bpsd_pkg::QW-1:0] val;
        for (int i = 0; i < 5; i++)
        begin
            idx = bpsd_pkg::cfg_idx_t'(i);
            case (idx)
                bpsd_pkg::CFG_WINDOW_LEN:     val = wl & 7'h7F;
                bpsd_pkg::CFG_UP_SLOPE_MIN:   val = up[31:0];
                bpsd_pkg::CFG_PEAK_RATIO_MAX: val = pk[31:0];
                bpsd_pkg::CFG_DOWN_SLOPE_MIN: val = lo[31:0];
                default:                      val = hi[31:0];
            endcase
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            case (idx)
                bpsd_pkg::CFG_WINDOW_LEN:
                begin
                    win_len_reg = val[bpsd_pkg::WLW-1:0];
                    restart_priming();
                end
                bpsd_pkg::CFG_UP_SLOPE_MIN:   up_min = longint'(signed'(val));
                bpsd_pkg::CFG_PEAK_RATIO_MAX: peak_max = longint'(signed'(val));
                bpsd_pkg::CFG_DOWN_SLOPE_MIN: band_lo = longint'(signed'(val));
                default:                      band_hi = longint'(signed'(val));
            endcase
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One breath: rest plateau, rise, top plateau, fall, bottom plateau.
    task automatic breathe(input int rise, input int dt, input int len, input int noise);
        int level;
        level = $urandom_range(0, 12000) - 22000;
        repeat ($urandom_range(2, len)) send_after($urandom_range(1, dt),
                                                   level + $urandom_range(0, noise));
        repeat (len)
        begin
            level += rise;
            send_after($urandom_range(1, dt), level + $urandom_range(0, noise));
        end
        repeat ($urandom_range(1, 4)) send_after($urandom_range(1, dt), level);
        repeat (len)
        begin
            level -= rise;
            send_after($urandom_range(1, dt), level - $urandom_range(0, noise));
        end
        repeat ($urandom_range(2, len)) send_after($urandom_range(1, dt), level);
    endtask

    // Defaults after reset, extreme values, repeated time stamps (zero
    // denominator) and a steep step that saturates the slope.
    task automatic test_defaults_and_extremes();
        for (int i = 0; i < 8; i++) send_after(1, i * 100);
        send_after(1, 32767);
        send_after(1, -32768);
        send_after(0, 32767);
        send_after(0, -32768);
        for (int i = 0; i < 13; i++) send_after(i % 3, (i % 2) ? 32767 : -32768);
        drain();
    endtask

    // Window lengths below, at and above the legal range; each write restarts priming.
    task automatic test_window_lengths();
        int lens[6] = '{0, 1, 2, 64, 65, 127};
        foreach (lens[j])
        begin
            program_limits(lens[j], 32768, 19660, -16384, 16384);
            for (int i = 0; i < 70; i++)
                send_after($urandom_range(1, 3), (i % 40 < 20) ? i * 300 : -i * 200);
            drain();
        end
    endtask

    // A flat signal with a negative up limit enters inhalation with a zero
    // earlier slope, so the peak can never be declared; then extreme limits.
    task automatic test_zero_slope_and_limits();
        program_limits(2, -1, SLOPE_MAX, SLOPE_MIN, SLOPE_MAX);
        repeat (8) send_after(1, 500);
        repeat (6) send_after(1, -32768 + $urandom_range(0, 65535));
        drain();
        program_limits(3, SLOPE_MIN, SLOPE_MIN, SLOPE_MAX, SLOPE_MIN);
        repeat (12) send_after($urandom_range(0, 2), -32768 + $urandom_range(0, 65535));
        drain();
        program_limits(3, SLOPE_MAX, SLOPE_MAX, SLOPE_MIN, SLOPE_MAX);
        repeat (12) send_after($urandom_range(0, 2), -32768 + $urandom_range(0, 65535));
        drain();
    endtask

    // Random breathing runs under random settings, with some noise items.
    task automatic test_random_breaths(input int items);
        int target;
        for (int s = 0; s < 6; s++)
        begin
            program_limits((s == 5) ? 64 : $urandom_range(2, 12),
                           $urandom_range(0, 131072) - 16384,
                           $urandom_range(0, 65536),
                           -longint'($urandom_range(4096, 65536)),
                           $urandom_range(4096, 65536));
            target = items / 6;
            while (target > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat (10) send_after($urandom_range(0, 3),
                                           -32768 + $urandom_range(0, 65535));
                    target -= 10;
                end
                else
                begin
                    breathe($urandom_range(50, 800), $urandom_range(1, 4), 10, 40);
                    target -= 40;
                end
            end
            drain();
        end
    endtask

    // Time stamps near the top of their range, with no idling on either side.
    task automatic test_top_of_time();
        calm = 1'b1;
        program_limits(6, 32768, 19660, -16384, 16384);
        clock_stamp = 20'hFFFFF - 20'd400;
        repeat (3) breathe($urandom_range(200, 600), 2, 10, 20);
        drain();
    endtask

    // Random receiver stalls, in bursts.
    always @(posedge clk)
    begin
        if (rdy_left > 0)
            rdy_left <= rdy_left - 1;
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            rdy_left <= $urandom_range(1, 20);
        end
        else
        begin
            out_ready <= 1'b0;
            rdy_left <= $urandom_range(0, 7);
        end
    end

    // Compare each event item with the oldest expectation.
    always @(posedge clk)
    begin
        breath_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: time %0d value %0d phase %0d",
                       event_time, event_value, event_phase);
                error_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_time !== want.t)
                begin
                    $error("event_time: expected %0d, got %0d", want.t, event_time);
                    error_count++;
                end
                if (event_value !== want.v)
                begin
                    $error("event_value: expected %0d, got %0d", want.v, event_value);
                    error_count++;
                end
                if (event_phase !== want.ph)
                begin
                    $error("event_phase: expected %0d, got %0d", want.ph, event_phase);
                    error_count++;
                end
            end
        end
    end

    // The run ends if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            ring_time[i] = 0;
            ring_value[i] = 0;
        end
        restart_priming();
        slope_now = 0;
        slope_prev = 0;
        breath_phase = bpsd_pkg::PH_REST;
        prev_value = 0;
        head = 0;
        win_len_reg = bpsd_pkg::WINDOW_LEN_RST;
        up_min = 0;
        peak_max = 0;
        band_lo = 0;
        band_hi = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults_and_extremes();
        test_window_lengths();
        test_zero_slope_and_limits();
        test_random_breaths(720);
        test_top_of_time();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
